/* hw/rtl/tspsd_pkg.sv */
// Package for the transport stream packet size detector.
// Holds the candidate packet lengths, register map, sync byte and phase entry type.
// No dependencies.
package tspsd_pkg;

	localparam int unsigned LEN_188 = 188;
	localparam int unsigned LEN_192 = 192;
	localparam int unsigned LEN_204 = 204;

	localparam logic [7:0] SYNC_BYTE = 8'h47;
	localparam logic [3:0] COUNT_MAX = 4'd15;
	localparam logic [3:0] REQUIRED_HITS_RESET = 4'd5;

	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_REQUIRED_HITS = 3'd0;

	localparam logic [7:0] RESULT_188 = 8'd188;
	localparam logic [7:0] RESULT_192 = 8'd192;
	localparam logic [7:0] RESULT_204 = 8'd204;
	localparam logic [7:0] RESULT_NONE = 8'd0;

	typedef struct packed {
		logic stop;
		logic [3:0] count;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic sync;
		logic restart;
		logic advance;
	} tspsd_ctl_t;

endpackage

/* hw/rtl/tspsd_phase_track.sv */
// Per-length phase tracker: position counter, phase memory and read-modify-write.
// Reads the phase entry on byte accept; updates and writes it back on ctl.advance.
// Depends on tspsd_pkg.
module tspsd_phase_track #(
	parameter int unsigned Length = tspsd_pkg::LEN_188
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tspsd_pkg::tspsd_ctl_t ctl,
	input  logic [3:0]            required_hits,
	output logic                  hit
);
	import tspsd_pkg::*;

	localparam int unsigned AddrW = $clog2(Length);
	localparam logic [AddrW-1:0] LastPos = AddrW'(Length - 1);

	logic [AddrW-1:0] pos_q;
	logic             first_q;
	logic [AddrW-1:0] addr_s1;
	logic             sync_s1;
	logic             first_s1;
	entry_t           rd_s1;
	entry_t           new_entry;
	entry_t           mem [Length];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			first_q <= 1'b1;
		end else if (ctl.accept) begin
			if (ctl.restart) begin
				pos_q   <= '0;
				first_q <= 1'b1;
			end else if (pos_q == LastPos) begin
				pos_q   <= '0;
				first_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			rd_s1    <= mem[pos_q];
			addr_s1  <= pos_q;
			sync_s1  <= ctl.sync;
			first_s1 <= first_q;
		end
		if (ctl.advance) begin
			mem[addr_s1] <= new_entry;
		end
	end

	always_comb begin
		new_entry = rd_s1;
		if (first_s1) begin
			new_entry.stop  = !sync_s1;
			new_entry.count = sync_s1 ? 4'd1 : 4'd0;
		end else if (!rd_s1.stop) begin
			if (sync_s1) begin
				if (rd_s1.count != COUNT_MAX) begin
					new_entry.count = rd_s1.count + 4'd1;
				end
			end else begin
				new_entry.stop = 1'b1;
			end
		end
	end

	assign hit = new_entry.count >= required_hits;

endmodule

/* hw/rtl/transport_stream_packet_size_detect_unit.sv */
// Transport stream packet size detector, top level.
// One byte per clock enters unless stalled; a result of 188, 192, 204 or 0 is
// emitted per buffer, after its last byte. Uses tspsd_pkg and tspsd_phase_track.
//
// Accepts one byte every clock while in_stall is low. The phase entry of each
// byte is read from a synchronous memory per length, then updated and written
// back. The result of a buffer is registered in the output register when its
// last byte leaves the read stage; input stalls only while that last byte waits
// behind an undelivered earlier result. No clearing pass is needed after reset.
module transport_stream_packet_size_detect_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              last_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        packet_length,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tspsd_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import tspsd_pkg::*;

	logic [3:0]  required_hits_q;
	logic        s1_valid_q;
	logic        last_s1;
	logic [2:0]  length_found_q;
	logic [2:0]  hits;
	logic [2:0]  found_now;
	logic        hold;
	logic        in_accept;
	logic        s1_fire;
	logic        out_valid_q;
	logic [7:0]  packet_length_q;
	logic [7:0]  result;
	tspsd_ctl_t  ctl;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_REQUIRED_HITS) ? {28'd0, required_hits_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			required_hits_q <= REQUIRED_HITS_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_REQUIRED_HITS) begin
			required_hits_q <= pwdata[3:0];
		end
	end

	// hold the last beat of a buffer while the previous result is undelivered
	assign hold      = s1_valid_q && last_s1 && out_valid_q && out_stall;
	assign in_stall  = hold;
	assign in_accept = in_valid && !hold;
	assign s1_fire   = s1_valid_q && !hold;

	assign ctl.accept  = in_accept;
	assign ctl.sync    = data_byte == SYNC_BYTE;
	assign ctl.restart = last_byte;
	assign ctl.advance = s1_fire;

	tspsd_phase_track #(.Length(LEN_188)) u_track_188 (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.required_hits(required_hits_q), .hit(hits[0])
	);

	tspsd_phase_track #(.Length(LEN_192)) u_track_192 (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.required_hits(required_hits_q), .hit(hits[1])
	);

	tspsd_phase_track #(.Length(LEN_204)) u_track_204 (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.required_hits(required_hits_q), .hit(hits[2])
	);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q     <= 1'b0;
			length_found_q <= 3'b000;
		end else begin
			if (!hold) begin
				s1_valid_q <= in_accept;
			end
			if (s1_fire) begin
				length_found_q <= last_s1 ? 3'b000 : found_now;
			end
		end
	end

	assign found_now = length_found_q | hits;

	always_comb begin
		if (found_now[0]) begin
			result = RESULT_188;
		end else if (found_now[1]) begin
			result = RESULT_192;
		end else if (found_now[2]) begin
			result = RESULT_204;
		end else begin
			result = RESULT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			packet_length_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign packet_length = packet_length_q;

endmodule
